[hdl/balloc_pkg.sv]
// Shared constants, codes and types for the block allocator with file table.
`default_nettype none

package balloc_pkg;

    localparam int NUM_BLOCKS      = 128;
    localparam int NUM_ENTRIES     = 16;
    localparam int MAX_FILE_BLOCKS = 8;

    localparam int BAW   = $clog2(NUM_BLOCKS);
    localparam int CW    = $clog2(NUM_BLOCKS + 1);
    localparam int EW    = $clog2(NUM_ENTRIES);
    localparam int ECW   = $clog2(NUM_ENTRIES + 1);
    localparam int IW    = $clog2(MAX_FILE_BLOCKS + 1);
    localparam int PTR_DEPTH = NUM_ENTRIES * MAX_FILE_BLOCKS;
    localparam int PAW   = $clog2(PTR_DEPTH);
    localparam int CMPW  = 8;

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_BLOCKS   = 3'd1;
    localparam logic [2:0] ST_NO_ENTRY    = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
    localparam logic [2:0] ST_INDEX_LARGE = 3'd4;
    localparam logic [2:0] ST_SIZE_LARGE  = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COUNT,
        S_CHECK,
        S_ESCAN,
        S_ALLOC,
        S_DEL,
        S_LWAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [BAW-1:0] rd_addr;
        logic           wr_en;
        logic [BAW-1:0] wr_addr;
        logic           wr_data;
    } t_map_req;

endpackage

`default_nettype wire

[hdl/balloc_blkmap.sv]
// Block in-use map: one-bit memory with per-block valid flags and registered read.
`default_nettype none

module balloc_blkmap
    import balloc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_map_req i_req,
    output logic          o_rd_data
);

    logic                  r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_vld;
    logic                  r_q;
    logic                  r_q_vld;
    logic                  r_q_zero;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_q      <= r_mem[i_req.rd_addr];
        r_q_zero <= (i_req.rd_addr == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            r_q_vld <= r_vld[i_req.rd_addr];
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    // Block zero reads as used until it is first written.
    assign o_rd_data = r_q_vld ? r_q : r_q_zero;

endmodule

`default_nettype wire

[hdl/block_allocator_with_file_table.sv]
// Top level: request sequencer, file-entry table and block pointer memory.
//
// Requests arrive on the input channel (i_valid, o_stall) and one result beat
// per request leaves on the output channel (o_valid, i_stall). A beat is taken
// when valid is high and stall is low. The block handles one request at a time
// and holds o_stall high from acceptance until the result is registered.
// Every request first walks the 128-entry block map, one block per cycle, to
// count free blocks. The entry table is then searched one entry per cycle
// with a single 64-bit name comparator. A create then walks the block map
// again to claim blocks, a delete frees one block per cycle for each block of
// the file, and a lookup reads the registered pointer memory and takes the
// block address in state S_LWAIT. The result sits in an output register; if
// the receiver stalls, the beat holds and the next request waits behind it in
// the final state. Reset empties the file table and marks only block zero in
// use.
`default_nettype none

module block_allocator_with_file_table
    import balloc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [63:0] i_file_name,
    input  wire logic [3:0]  i_file_blocks,
    input  wire logic [2:0]  i_block_index,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [6:0]       o_block_addr,
    output logic [7:0]       o_free_count
);

    t_state r_state, n_state;

    logic [1:0]  r_op;
    logic [63:0] r_name;
    logic [3:0]  r_want;
    logic [2:0]  r_idx;

    logic [CW-1:0]  r_bcnt, n_bcnt;
    logic           r_pend, n_pend;
    logic [BAW-1:0] r_rd_blk, n_rd_blk;
    logic [CW-1:0]  r_free, n_free;
    logic [ECW-1:0] r_ent, n_ent;
    logic [IW-1:0]  r_i, n_i;
    logic [2:0]     r_status, n_status;
    logic [BAW-1:0] r_addr, n_addr;

    logic           r_o_valid, n_o_valid;
    logic [2:0]     r_o_status, n_o_status;
    logic [6:0]     r_o_addr, n_o_addr;
    logic [7:0]     r_o_free, n_o_free;

    logic [NUM_ENTRIES-1:0] r_used, n_used;
    logic [63:0]            r_ename [NUM_ENTRIES];
    logic [3:0]             r_esize [NUM_ENTRIES];
    logic                   ent_we;

    logic [BAW-1:0] r_ptr_mem [PTR_DEPTH];
    logic [BAW-1:0] r_ptr_q;
    logic           ptr_we;
    logic [PAW-1:0] ptr_wa;
    logic [PAW-1:0] ptr_ra;

    t_map_req map_req;
    logic     map_rd;

    logic [EW-1:0] ent;
    logic          is_create;
    logic          is_delete;
    logic          hit;
    logic          load_out;

    balloc_blkmap u_blkmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (map_req),
        .o_rd_data (map_rd)
    );

    assign ent       = r_ent[EW-1:0];
    assign is_create = (r_op == OP_CREATE);
    assign is_delete = (r_op == OP_DELETE);
    assign hit       = is_create ? !r_used[ent] : (r_used[ent] && (r_ename[ent] == r_name));

    always_comb begin
        n_state    = r_state;
        n_bcnt     = r_bcnt;
        n_pend     = 1'b0;
        n_rd_blk   = r_rd_blk;
        n_free     = r_free;
        n_ent      = r_ent;
        n_i        = r_i;
        n_status   = r_status;
        n_addr     = r_addr;
        n_used     = r_used;
        ent_we     = 1'b0;
        ptr_we     = 1'b0;
        ptr_wa     = PAW'(ent) * PAW'(MAX_FILE_BLOCKS) + PAW'(r_i);
        ptr_ra     = PAW'(ent) * PAW'(MAX_FILE_BLOCKS) + PAW'(r_i);
        map_req.rd_addr = r_bcnt[BAW-1:0];
        map_req.wr_en   = 1'b0;
        map_req.wr_addr = r_rd_blk;
        map_req.wr_data = 1'b0;
        load_out   = 1'b0;
        o_stall    = (r_state != S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_bcnt  = '0;
                    n_free  = '0;
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                if (r_bcnt != CW'(NUM_BLOCKS)) begin
                    n_bcnt   = r_bcnt + 1'b1;
                    n_pend   = 1'b1;
                end
                if (r_pend && !map_rd) begin
                    n_free = r_free + 1'b1;
                end
                if (r_bcnt == CW'(NUM_BLOCKS) && !r_pend) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_ent    = '0;
                n_addr   = '0;
                n_status = ST_OK;
                n_state  = S_ESCAN;
                if (is_create) begin
                    if (CMPW'(r_want) > CMPW'(MAX_FILE_BLOCKS)) begin
                        n_status = ST_SIZE_LARGE;
                        n_state  = S_DONE;
                    end else if (r_free < CW'(r_want)) begin
                        n_status = ST_NO_BLOCKS;
                        n_state  = S_DONE;
                    end
                end
            end
            S_ESCAN: begin
                ptr_ra = PAW'(ent) * PAW'(MAX_FILE_BLOCKS) + PAW'(r_idx);
                if (r_ent == ECW'(NUM_ENTRIES)) begin
                    n_status = is_create ? ST_NO_ENTRY : ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else if (hit) begin
                    n_i    = '0;
                    n_bcnt = '0;
                    if (is_create) begin
                        n_used[ent] = 1'b1;
                        ent_we      = 1'b1;
                        n_state     = S_ALLOC;
                    end else if (is_delete) begin
                        n_state = S_DEL;
                    end else if (CMPW'(r_idx) >= CMPW'(r_esize[ent])
                                 || CMPW'(r_idx) >= CMPW'(MAX_FILE_BLOCKS)) begin
                        n_status = ST_INDEX_LARGE;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_LWAIT;
                    end
                end else begin
                    n_ent = r_ent + 1'b1;
                end
            end
            S_ALLOC: begin
                if (CMPW'(r_i) == CMPW'(r_want)) begin
                    n_state = S_DONE;
                end else begin
                    if (r_bcnt != CW'(NUM_BLOCKS)) begin
                        n_bcnt   = r_bcnt + 1'b1;
                        n_pend   = 1'b1;
                        n_rd_blk = r_bcnt[BAW-1:0];
                    end
                    if (r_pend && !map_rd) begin
                        map_req.wr_en   = 1'b1;
                        map_req.wr_data = 1'b1;
                        ptr_we          = 1'b1;
                        n_i             = r_i + 1'b1;
                    end
                end
            end
            S_DEL: begin
                map_req.wr_addr = r_ptr_q;
                if (CMPW'(r_i) < CMPW'(r_esize[ent]) && CMPW'(r_i) < CMPW'(MAX_FILE_BLOCKS)) begin
                    n_i    = r_i + 1'b1;
                    n_pend = 1'b1;
                end
                if (r_pend) begin
                    map_req.wr_en = 1'b1;
                end
                if (n_pend == 1'b0 && !r_pend) begin
                    n_used[ent] = 1'b0;
                    n_state     = S_DONE;
                end
            end
            S_LWAIT: begin
                n_addr  = r_ptr_q;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_o_valid  = r_o_valid && i_stall;
        n_o_status = r_o_status;
        n_o_addr   = r_o_addr;
        n_o_free   = r_o_free;
        if (load_out) begin
            n_o_valid  = 1'b1;
            n_o_status = r_status;
            n_o_addr   = 7'(r_addr);
            n_o_free   = 8'(r_free);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_bcnt    <= '0;
            r_pend    <= 1'b0;
            r_free    <= '0;
            r_ent     <= '0;
            r_i       <= '0;
            r_status  <= ST_OK;
            r_used    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bcnt    <= n_bcnt;
            r_pend    <= n_pend;
            r_free    <= n_free;
            r_ent     <= n_ent;
            r_i       <= n_i;
            r_status  <= n_status;
            r_used    <= n_used;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op   <= i_op;
            r_name <= i_file_name;
            r_want <= i_file_blocks;
            r_idx  <= i_block_index;
        end
        r_rd_blk   <= n_rd_blk;
        r_addr     <= n_addr;
        r_o_status <= n_o_status;
        r_o_addr   <= n_o_addr;
        r_o_free   <= n_o_free;
        if (ent_we) begin
            r_ename[ent] <= r_name;
            r_esize[ent] <= r_want;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ptr_we) begin
            r_ptr_mem[ptr_wa] <= r_rd_blk;
        end
        r_ptr_q <= r_ptr_mem[ptr_ra];
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_block_addr = r_o_addr;
    assign o_free_count = r_o_free;

endmodule

`default_nettype wire
